### rtl/pbwfp_pkg.sv
`timescale 1ns / 1ps
// Package for the wire field parser: item types, token kinds, error codes
// and parse phase codes. No dependencies.
package pbwfp_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  token_kind;
        logic [31:0] field_id;
        logic [2:0]  wire_kind;
        logic [63:0] token_value;
        logic [1:0]  error_code;
        logic        end_of_message;
    } out_item_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } queue_item_t;

    localparam logic [2:0] TK_HEADER  = 3'd0;
    localparam logic [2:0] TK_VARINT  = 3'd1;
    localparam logic [2:0] TK_FIXED32 = 3'd2;
    localparam logic [2:0] TK_FIXED64 = 3'd3;
    localparam logic [2:0] TK_LENGTH  = 3'd4;
    localparam logic [2:0] TK_PAYLOAD = 3'd5;
    localparam logic [2:0] TK_ERROR   = 3'd6;

    localparam logic [1:0] ERR_TRUNCATED = 2'd0;
    localparam logic [1:0] ERR_TOO_LONG  = 2'd1;
    localparam logic [1:0] ERR_WIRE_TYPE = 2'd2;
    localparam logic [1:0] ERR_FIELD_0   = 2'd3;

    localparam logic [2:0] WT_VARINT = 3'd0;
    localparam logic [2:0] WT_FIX64  = 3'd1;
    localparam logic [2:0] WT_LEN    = 3'd2;
    localparam logic [2:0] WT_FIX32  = 3'd5;

    localparam logic [2:0] PH_TAG     = 3'd0;
    localparam logic [2:0] PH_VARINT  = 3'd1;
    localparam logic [2:0] PH_FIX64   = 3'd2;
    localparam logic [2:0] PH_FIX32   = 3'd3;
    localparam logic [2:0] PH_LEN     = 3'd4;
    localparam logic [2:0] PH_PAYLOAD = 3'd5;
    localparam logic [2:0] PH_DRAIN   = 3'd6;

    localparam int QUEUE_DEPTH = 2;

endpackage

### rtl/protobuf_wire_field_parser_unit.sv
`timescale 1ns / 1ps
// Wire format tokenizer top level; depends on pbwfp_pkg, pbwfp_front, pbwfp_back.
// Throughput: one byte per cycle, sustained while tokens are taken.
// Path: each accepted byte waits in the two-entry input queue, and any token it
// yields is held in the output register until it is taken.
// Reset: synchronous active-low aresetn empties the queue and rearms at a tag.
module protobuf_wire_field_parser_unit (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  pbwfp_pkg::in_item_t  s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output pbwfp_pkg::out_item_t m_data
);
    import pbwfp_pkg::*;

    logic        q_valid;
    logic        q_ready;
    queue_item_t q_data;

    pbwfp_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_data  (q_data)
    );

    pbwfp_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_data  (q_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

### rtl/pbwfp_front.sv
`timescale 1ns / 1ps
// Front end: accepts input items into a two-entry queue for the parser.
// Depends on pbwfp_pkg.
module pbwfp_front (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  pbwfp_pkg::in_item_t    s_data,
    output logic                   q_valid,
    input  logic                   q_ready,
    output pbwfp_pkg::queue_item_t q_data
);
    import pbwfp_pkg::*;

    queue_item_t mem_reg [QUEUE_DEPTH];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  count_reg;
    logic        push;
    logic        pop;

    assign s_ready = (count_reg != 2'(QUEUE_DEPTH));
    assign q_valid = (count_reg != 2'd0);
    assign q_data  = mem_reg[rd_ptr_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_valid && q_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg].data_byte <= s_data.data_byte;
            mem_reg[wr_ptr_reg].last_byte <= s_data.last_byte;
        end
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)  rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_reg + 2'(push) - 2'(pop);
        end
    end

endmodule

### rtl/pbwfp_back.sv
`timescale 1ns / 1ps
// Back end: wire format state machine with a registered output stage.
// Depends on pbwfp_pkg.
module pbwfp_back (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   q_valid,
    output logic                   q_ready,
    input  pbwfp_pkg::queue_item_t q_data,
    output logic                   m_valid,
    input  logic                   m_ready,
    output pbwfp_pkg::out_item_t   m_data
);
    import pbwfp_pkg::*;

    logic [2:0]  phase_reg, phase_next;
    logic [63:0] acc_reg, acc_next;
    logic [3:0]  pos_reg, pos_next;
    logic [31:0] field_reg, field_next;
    logic [2:0]  wt_reg, wt_next;
    logic [63:0] rem_reg, rem_next;
    logic        out_valid_reg;
    out_item_t   out_reg;
    out_item_t   tok;
    logic        emit;
    logic        step;
    logic [7:0]  b;
    logic        last;
    logic [63:0] acc_v;
    logic [63:0] acc_f;
    logic [5:0]  sh7;
    logic [5:0]  sh8;
    logic [3:0]  pos_inc;
    logic [31:0] tag_field;
    logic [2:0]  tag_wt;

    assign q_ready = !out_valid_reg || m_ready;
    assign step    = q_valid && q_ready;
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;
    assign b       = q_data.data_byte;
    assign last    = q_data.last_byte;
    assign sh7     = 6'((7 * pos_reg) & 63);
    assign sh8     = {pos_reg[2:0], 3'b000};
    assign acc_v   = acc_reg | ({57'd0, b[6:0]} << sh7);
    assign acc_f   = acc_reg | ({56'd0, b} << sh8);
    assign pos_inc = pos_reg + 4'd1;
    assign tag_field = acc_v[34:3];
    assign tag_wt    = acc_v[2:0];

    always_comb begin
        phase_next = phase_reg;
        acc_next   = acc_reg;
        pos_next   = pos_reg;
        field_next = field_reg;
        wt_next    = wt_reg;
        rem_next   = rem_reg;
        emit       = 1'b0;
        tok.token_kind     = TK_HEADER;
        tok.field_id       = field_reg;
        tok.wire_kind      = wt_reg;
        tok.token_value    = 64'd0;
        tok.error_code     = ERR_TRUNCATED;
        tok.end_of_message = last;
        case (phase_reg)
            PH_DRAIN: begin
                if (last) phase_next = PH_TAG;
            end
            PH_TAG, PH_VARINT, PH_LEN: begin
                if (b[7]) begin
                    if (pos_reg >= 4'd9 || last) begin
                        emit = 1'b1;
                        tok.token_kind = TK_ERROR;
                        tok.error_code = (pos_reg >= 4'd9) ? ERR_TOO_LONG : ERR_TRUNCATED;
                    end else begin
                        acc_next = acc_v;
                        pos_next = pos_inc;
                    end
                end else begin
                    acc_next = 64'd0;
                    pos_next = 4'd0;
                    emit     = 1'b1;
                    if (phase_reg == PH_TAG) begin
                        tok.field_id     = tag_field;
                        tok.wire_kind    = tag_wt;
                        field_next       = tag_field;
                        wt_next          = tag_wt;
                        tok.token_kind   = TK_ERROR;
                        if (tag_field == 32'd0) begin
                            tok.error_code = ERR_FIELD_0;
                        end else if (tag_wt != WT_VARINT && tag_wt != WT_FIX64 &&
                                     tag_wt != WT_LEN && tag_wt != WT_FIX32) begin
                            tok.error_code = ERR_WIRE_TYPE;
                        end else if (!last) begin
                            tok.token_kind     = TK_HEADER;
                            tok.end_of_message = 1'b0;
                            case (tag_wt)
                                WT_VARINT: phase_next = PH_VARINT;
                                WT_FIX64:  phase_next = PH_FIX64;
                                WT_FIX32:  phase_next = PH_FIX32;
                                default:   phase_next = PH_LEN;
                            endcase
                        end
                    end else if (phase_reg == PH_VARINT) begin
                        tok.token_kind  = TK_VARINT;
                        tok.token_value = acc_v;
                        phase_next      = PH_TAG;
                        field_next      = 32'd0;
                        wt_next         = 3'd0;
                    end else if (acc_v == 64'd0 || !last) begin
                        tok.token_kind  = TK_LENGTH;
                        tok.token_value = acc_v;
                        if (acc_v == 64'd0) begin
                            phase_next = PH_TAG;
                            field_next = 32'd0;
                            wt_next    = 3'd0;
                        end else begin
                            rem_next   = acc_v;
                            phase_next = PH_PAYLOAD;
                        end
                    end else begin
                        tok.token_kind = TK_ERROR;
                    end
                end
            end
            PH_FIX32, PH_FIX64: begin
                if (pos_inc >= ((phase_reg == PH_FIX32) ? 4'd4 : 4'd8)) begin
                    emit = 1'b1;
                    tok.token_kind  = (phase_reg == PH_FIX32) ? TK_FIXED32 : TK_FIXED64;
                    tok.token_value = acc_f;
                    acc_next   = 64'd0;
                    pos_next   = 4'd0;
                    phase_next = PH_TAG;
                    field_next = 32'd0;
                    wt_next    = 3'd0;
                end else if (last) begin
                    emit = 1'b1;
                    tok.token_kind = TK_ERROR;
                end else begin
                    acc_next = acc_f;
                    pos_next = pos_inc;
                end
            end
            PH_PAYLOAD: begin
                emit = 1'b1;
                tok.token_value = {56'd0, b};
                if (rem_reg <= 64'd1) begin
                    tok.token_kind = TK_PAYLOAD;
                    phase_next = PH_TAG;
                    rem_next   = 64'd0;
                    field_next = 32'd0;
                    wt_next    = 3'd0;
                end else if (last) begin
                    tok.token_kind  = TK_ERROR;
                    tok.token_value = 64'd0;
                end else begin
                    tok.token_kind = TK_PAYLOAD;
                    rem_next = rem_reg - 64'd1;
                end
            end
            default: begin
                phase_next = PH_TAG;
            end
        endcase
        if (emit && tok.token_kind == TK_ERROR) begin
            phase_next = last ? PH_TAG : PH_DRAIN;
            acc_next   = 64'd0;
            pos_next   = 4'd0;
            field_next = 32'd0;
            wt_next    = 3'd0;
            rem_next   = 64'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step && emit) out_reg <= tok;
        if (!aresetn) begin
            phase_reg     <= PH_TAG;
            acc_reg       <= 64'd0;
            pos_reg       <= 4'd0;
            field_reg     <= 32'd0;
            wt_reg        <= 3'd0;
            rem_reg       <= 64'd0;
            out_valid_reg <= 1'b0;
        end else begin
            if (step) begin
                phase_reg <= phase_next;
                acc_reg   <= acc_next;
                pos_reg   <= pos_next;
                field_reg <= field_next;
                wt_reg    <= wt_next;
                rem_reg   <= rem_next;
            end
            if (q_ready) out_valid_reg <= step && emit;
        end
    end

endmodule

### bench/protobuf_wire_field_parser_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for the wire format tokenizer: byte items go in, tokens
// are predicted in step and compared in order as whole tokens. Depends on pbwfp_pkg.
module protobuf_wire_field_parser_unit_tb;
    import pbwfp_pkg::*;

    localparam int LATENCY = 3;
    localparam int WATCHDOG_LIMIT = 20000;

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    in_item_t s_data;
    logic m_valid;
    logic m_ready;
    out_item_t m_data;

    protobuf_wire_field_parser_unit u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    // Predictor state.
    logic [2:0]  phase;
    logic [63:0] accum;
    logic [3:0]  bpos;
    logic [31:0] cur_field;
    logic [2:0]  cur_wt;
    logic [63:0] remaining;

    out_item_t expected_tokens[$];
    int sent_bytes;
    int token_count;
    int error_tokens;
    int mismatches;
    int idle_cycles;
    bit timed_out;
    int send_idle_pct;
    int recv_stall_pct;

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    task automatic rearm_parser();
        phase = PH_TAG;
        accum = '0;
        bpos = '0;
        cur_field = '0;
        cur_wt = '0;
        remaining = '0;
    endtask

    task automatic push_token(input logic [2:0] kind, input logic [63:0] value,
                              input logic [1:0] code, input logic eom);
        out_item_t t;
        t.token_kind = kind;
        t.field_id = cur_field;
        t.wire_kind = cur_wt;
        t.token_value = value;
        t.error_code = code;
        t.end_of_message = eom;
        expected_tokens.push_back(t);
    endtask

    task automatic push_error(input logic [1:0] code, input logic last);
        push_token(TK_ERROR, 64'd0, code, last);
        rearm_parser();
        if (!last) begin
            phase = PH_DRAIN;
        end
    endtask

    task automatic predict_token(input logic [7:0] b, input logic last);
        logic [63:0] v;
        int need;
        case (phase)
            PH_DRAIN: begin
                if (last) begin
                    rearm_parser();
                end
            end
            PH_TAG, PH_VARINT, PH_LEN: begin
                accum = accum | (64'(b[6:0]) << ((7 * bpos) % 64));
                if (b[7]) begin
                    if (bpos >= 9) begin
                        push_error(ERR_TOO_LONG, last);
                    end else if (last) begin
                        push_error(ERR_TRUNCATED, last);
                    end else begin
                        bpos = bpos + 4'd1;
                    end
                end else begin
                    v = accum;
                    accum = '0;
                    bpos = '0;
                    if (phase == PH_TAG) begin
                        cur_field = v[34:3];
                        cur_wt = v[2:0];
                        if (cur_field == 0) begin
                            push_error(ERR_FIELD_0, last);
                        end else if (cur_wt != WT_VARINT && cur_wt != WT_FIX64 &&
                                     cur_wt != WT_LEN && cur_wt != WT_FIX32) begin
                            push_error(ERR_WIRE_TYPE, last);
                        end else if (last) begin
                            push_error(ERR_TRUNCATED, last);
                        end else begin
                            case (cur_wt)
                                WT_VARINT: phase = PH_VARINT;
                                WT_FIX64:  phase = PH_FIX64;
                                WT_FIX32:  phase = PH_FIX32;
                                default:   phase = PH_LEN;
                            endcase
                            push_token(TK_HEADER, 64'd0, ERR_TRUNCATED, 1'b0);
                        end
                    end else if (phase == PH_VARINT) begin
                        push_token(TK_VARINT, v, ERR_TRUNCATED, last);
                        rearm_parser();
                    end else if (v == 0) begin
                        push_token(TK_LENGTH, 64'd0, ERR_TRUNCATED, last);
                        rearm_parser();
                    end else if (last) begin
                        push_error(ERR_TRUNCATED, last);
                    end else begin
                        push_token(TK_LENGTH, v, ERR_TRUNCATED, 1'b0);
                        remaining = v;
                        phase = PH_PAYLOAD;
                    end
                end
            end
            PH_FIX32, PH_FIX64: begin
                need = (phase == PH_FIX32) ? 4 : 8;
                accum = accum | (64'(b) << ((8 * bpos) % 64));
                bpos = bpos + 4'd1;
                if (bpos >= need) begin
                    push_token((phase == PH_FIX32) ? TK_FIXED32 : TK_FIXED64, accum,
                               ERR_TRUNCATED, last);
                    rearm_parser();
                end else if (last) begin
                    push_error(ERR_TRUNCATED, last);
                end
            end
            PH_PAYLOAD: begin
                if (remaining <= 1) begin
                    push_token(TK_PAYLOAD, 64'(b), ERR_TRUNCATED, last);
                    rearm_parser();
                end else if (last) begin
                    push_error(ERR_TRUNCATED, last);
                end else begin
                    remaining = remaining - 64'd1;
                    push_token(TK_PAYLOAD, 64'(b), ERR_TRUNCATED, 1'b0);
                end
            end
            default: begin
                rearm_parser();
            end
        endcase
    endtask

    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= '{data_byte: b, last_byte: last};
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        predict_token(b, last);
        sent_bytes++;
    endtask

    task automatic send_varint(input logic [63:0] v, input logic last);
        do begin
            send_byte({(v >> 7) != 0, v[6:0]}, last && ((v >> 7) == 0));
            v = v >> 7;
        end while (v != 0);
    endtask

    task automatic send_tag(input logic [31:0] field, input logic [2:0] wt);
        send_varint({29'd0, field, wt}, 1'b0);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (expected_tokens.size() != 0 && !timed_out) begin
            @(posedge aclk);
        end
        repeat (LATENCY + 2) @(posedge aclk);
    endtask

    always @(posedge aclk) begin
        if (aresetn) begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end else begin
            m_ready <= 1'b0;
        end
        if (aresetn && m_valid && m_ready) begin
            token_count++;
            if (m_data.token_kind == TK_ERROR) begin
                error_tokens++;
            end
            if (expected_tokens.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected token %p", m_data);
                end
            end else begin
                if (m_data !== expected_tokens[0]) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("token mismatch: expected %p, got %p",
                                 expected_tokens[0], m_data);
                    end
                end
                void'(expected_tokens.pop_front());
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
            timed_out = 1'b1;
            $display("status: fail");
            $finish;
        end
    end

    task automatic test_directed();
        send_tag(32'd1, WT_VARINT);
        send_varint(64'd0, 1'b0);
        send_tag(32'hFFFF_FFFF, WT_VARINT);
        send_varint(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
        send_tag(32'd2, WT_FIX32);
        for (int i = 0; i < 4; i++) send_byte(8'hA0 + 8'(i), 1'b0);
        send_tag(32'd3, WT_FIX64);
        for (int i = 0; i < 8; i++) send_byte(8'hF8 - 8'(i), 1'b0);
        send_tag(32'd4, WT_LEN);
        send_varint(64'd0, 1'b0);
        send_tag(32'd5, WT_LEN);
        send_varint(64'd2, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
    endtask

    task automatic test_errors();
        send_byte(8'h08, 1'b1);
        send_byte(8'h02, 1'b0);
        send_byte(8'h55, 1'b1);
        send_byte(8'h0B, 1'b0);
        send_byte(8'h00, 1'b1);
        send_tag(32'd6, WT_VARINT);
        for (int i = 0; i < 10; i++) send_byte(8'hFF, 1'b0);
        send_byte(8'h01, 1'b1);
        send_tag(32'd7, WT_VARINT);
        for (int i = 0; i < 9; i++) send_byte(8'h80, 1'b0);
        send_byte(8'h7F, 1'b1);
        send_tag(32'd8, WT_LEN);
        send_byte(8'h05, 1'b1);
        send_byte(8'h88, 1'b1);
    endtask

    task automatic send_random_field(input logic last_field);
        logic [31:0] field;
        logic [2:0] wt;
        logic [63:0] v;
        int n;
        field = ($urandom_range(3) == 0) ? $urandom() : $urandom_range(1, 40);
        case ($urandom_range(3))
            0: wt = WT_VARINT;
            1: wt = WT_FIX64;
            2: wt = WT_FIX32;
            default: wt = WT_LEN;
        endcase
        send_tag(field, wt);
        case (wt)
            WT_VARINT: begin
                v = {$urandom(), $urandom()} >> $urandom_range(63);
                send_varint(v, last_field);
            end
            WT_FIX32, WT_FIX64: begin
                n = (wt == WT_FIX32) ? 4 : 8;
                for (int i = 0; i < n; i++) begin
                    send_byte(8'($urandom()), last_field && i == n - 1);
                end
            end
            default: begin
                n = $urandom_range(0, 6);
                send_varint(64'(n), last_field && n == 0);
                for (int i = 0; i < n; i++) begin
                    send_byte(8'($urandom()), last_field && i == n - 1);
                end
            end
        endcase
    endtask

    task automatic test_random(input int budget);
        int goal;
        goal = sent_bytes + budget;
        while (sent_bytes < goal) begin
            if ($urandom_range(9) < 8) begin
                repeat ($urandom_range(1, 4)) send_random_field(1'b0);
                send_random_field(1'b1);
            end else begin
                repeat ($urandom_range(1, 8)) send_byte(8'($urandom()), 1'b0);
                send_byte(8'($urandom()), 1'b1);
            end
        end
    endtask

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        sent_bytes = 0;
        token_count = 0;
        error_tokens = 0;
        mismatches = 0;
        idle_cycles = 0;
        timed_out = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        rearm_parser();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_errors();
        wait_drained();
        test_random(400);
        send_idle_pct = 61;
        test_random(380);
        wait_drained();
        send_idle_pct = 0;
        recv_stall_pct = 61;
        test_random(380);
        send_idle_pct = 33;
        recv_stall_pct = 33;
        test_random(380);
        wait_drained();
        $display("Sent %0d bytes and checked %0d tokens, %0d of them errors.",
                 sent_bytes, token_count, error_tokens);
        if (mismatches == 0 && expected_tokens.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
